// ----- hw/rtl/tds_pkg.sv -----
`default_nettype none
package tds_pkg;

  localparam int FRAC_BITS   = 19;
  localparam int CURVE_KNOTS = 65;
  localparam int COEF_SHIFT  = 24;
  localparam int POST_SHIFT  = 20;

  localparam int PW = 56;  // product register width

  localparam logic [27:0] TABLE_UNIT = 28'd100000000;
  localparam logic [49:0] HALF_UNIT  = 50'd50000000;

  // floor(2^57 / TABLE_UNIT), applied to the magnitude shifted down by 26
  localparam logic [30:0] UNIT_RECIP  = 31'd1441151880;
  localparam int          RECIP_SHIFT = 31;

  localparam logic signed [27:0] OUT_MAX = 28'sh7FFFFFF;
  localparam logic signed [27:0] OUT_MIN = -28'sh8000000;

  typedef enum logic [2:0] {
    REG_BYPASS    = 3'd0,
    REG_PRE_GAIN  = 3'd1,
    REG_POST_GAIN = 3'd2,
    REG_ATTACK    = 3'd3,
    REG_RELEASE   = 3'd4,
    REG_HIGHPASS  = 3'd5,
    REG_DEPTH     = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        bypass;
    logic [24:0] pre_gain;
    logic [23:0] post_gain;
    logic [22:0] attack_coeff;
    logic [22:0] release_coeff;
    logic [22:0] highpass_coeff;
    logic [23:0] bias_depth;
  } tds_cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_X_PRE, MUL_C_DIFF, MUL_BIAS_E, MUL_T_T, MUL_T2_T,
    MUL_VAL0_H00, MUL_SLP0_H10, MUL_VAL1_H01, MUL_SLP1_H11,
    MUL_HP_DIFF, MUL_POST_DIFF, MUL_N_RECIP, MUL_Q_UNIT
  } mul_sel_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_WB_S, OP_WB_ENV, OP_WB_U, OP_SEG, OP_WB_T2, OP_WB_T3,
    OP_ACC_LD, OP_ACC_ADD, OP_DIV_LD, OP_WB_Q, OP_WB_Y, OP_WB_LP,
    OP_WB_R, OP_WB_BYP
  } dp_op_e;

  typedef struct packed {
    logic     load_in;
    logic     load_out;
    mul_sel_e mul_sel;
    dp_op_e   op;
  } tds_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BYP, ST_MPRE, ST_WS, ST_MENV, ST_WE, ST_MBIAS, ST_WU, ST_SEG,
    ST_MT2, ST_WT2, ST_MT3, ST_WT3, ST_A0, ST_A1, ST_A2, ST_A3, ST_A4,
    ST_DLD, ST_MQ, ST_WQ, ST_MQD, ST_WY, ST_MHP, ST_WLP, ST_MPOST, ST_WR, ST_DONE
  } tds_state_e;

  localparam logic signed [29:0] KNOT_VAL [CURVE_KNOTS] = '{
    -30'sd183117718, -30'sd183117686, -30'sd183117628, -30'sd183117523,
    -30'sd183117330, -30'sd183116975, -30'sd183116326, -30'sd183115133,
    -30'sd183112952, -30'sd183108959, -30'sd183101646, -30'sd183088264,
    -30'sd183063804, -30'sd183019157, -30'sd182937878, -30'sd182790531,
    -30'sd182525228, -30'sd182052744, -30'sd181225570, -30'sd179814322,
    -30'sd177493380, -30'sd173856573, -30'sd168478192, -30'sd161003709,
    -30'sd151222469, -30'sd139084589, -30'sd124667692, -30'sd108125568,
    -30'sd89644463, -30'sd69415571, -30'sd47621058, -30'sd24430191,
    30'sd0, 30'sd25521777, 30'sd51991899, 30'sd79267015,
    30'sd107199119, 30'sd135631098, 30'sd164390723, 30'sd193275676,
    30'sd221145404, 30'sd242929576, 30'sd262298018, 30'sd280369688,
    30'sd296894186, 30'sd311371244, 30'sd323401880, 30'sd332955532,
    30'sd340363520, 30'sd346099037, 30'sd350595812, 30'sd354186930,
    30'sd357110937, 30'sd359535284, 30'sd361578152, 30'sd363324061,
    30'sd364834588, 30'sd366155453, 30'sd367321225, 30'sd368358498,
    30'sd369288052, 30'sd370126356, 30'sd370886638, 30'sd371579644,
    30'sd372214200
  };

  localparam logic signed [25:0] KNOT_SLOPE [CURVE_KNOTS] = '{
    26'sd0, 26'sd45, 26'sd81, 26'sd149, 26'sd274,
    26'sd502, 26'sd921, 26'sd1687, 26'sd3087, 26'sd5653,
    26'sd10348, 26'sd18921, 26'sd34554, 26'sd62963, 26'sd114313,
    26'sd206325, 26'sd368893, 26'sd649829, 26'sd1119211, 26'sd1866095,
    26'sd2978874, 26'sd4507594, 26'sd6426432, 26'sd8627862, 26'sd10959560,
    26'sd13277388, 26'sd15479511, 26'sd17511615, 26'sd19354998, 26'sd21011703,
    26'sd22492690, 26'sd23810529, 26'sd24975984, 26'sd25995950, 26'sd26872619,
    26'sd27603610, 26'sd28182041, 26'sd28595802, 26'sd28822289, 26'sd28377341,
    26'sd24826950, 26'sd20576307, 26'sd18720056, 26'sd17298084, 26'sd15500778,
    26'sd13253847, 26'sd10792144, 26'sd8480820, 26'sd6571752, 26'sd5116146,
    26'sd4043947, 26'sd3257562, 26'sd2674177, 26'sd2233607, 26'sd1894388,
    26'sd1628218, 26'sd1415696, 26'sd1243318, 26'sd1101523, 26'sd983413,
    26'sd883929, 26'sd799293, 26'sd726644, 26'sd663781, 26'sd0
  };

  // shift right, rounding half away from zero
  function automatic logic signed [PW-1:0] round_shift(input logic signed [PW-1:0] v,
                                                       input int unsigned sh);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    r = (m + (PW'(1) << (sh - 1))) >> sh;
    return v[PW-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/triode_drive_stage_top.sv -----
// the input is stalled until the last sample's result has entered the output register;
// the shared 32x32 multiplier forms one product per multiply step, and bypass skips it
// the next sample is taken while a finished result still waits at the output,
// and its own result then holds until that beat has left
// reset: asynchronous, active low; registers to defaults, envelope and dc tracker to zero
`default_nettype none
module triode_drive_stage_top
  import tds_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [23:0] sample_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [27:0]      sample_out_o
);

  tds_cfg_t cfg;
  tds_cmd_t cmd;

  tds_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bypass_i    (cfg.bypass),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tds_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/tds_regs.sv -----
`default_nettype none
module tds_regs
  import tds_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output tds_cfg_t         cfg_o
);

  tds_cfg_t cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bypass         <= 1'b1;
      cfg_q.pre_gain       <= 25'd2097152;
      cfg_q.post_gain      <= 24'd8388608;
      cfg_q.attack_coeff   <= 23'd69760;
      cfg_q.release_coeff  <= 23'd6989;
      cfg_q.highpass_coeff <= 23'd21946;
      cfg_q.bias_depth     <= 24'd620757;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_BYPASS:    cfg_q.bypass         <= pwdata[0];
        REG_PRE_GAIN:  cfg_q.pre_gain       <= pwdata[24:0];
        REG_POST_GAIN: cfg_q.post_gain      <= pwdata[23:0];
        REG_ATTACK:    cfg_q.attack_coeff   <= pwdata[22:0];
        REG_RELEASE:   cfg_q.release_coeff  <= pwdata[22:0];
        REG_HIGHPASS:  cfg_q.highpass_coeff <= pwdata[22:0];
        REG_DEPTH:     cfg_q.bias_depth     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BYPASS:    prdata = {31'd0, cfg_q.bypass};
      REG_PRE_GAIN:  prdata = {7'd0, cfg_q.pre_gain};
      REG_POST_GAIN: prdata = {8'd0, cfg_q.post_gain};
      REG_ATTACK:    prdata = {9'd0, cfg_q.attack_coeff};
      REG_RELEASE:   prdata = {9'd0, cfg_q.release_coeff};
      REG_HIGHPASS:  prdata = {9'd0, cfg_q.highpass_coeff};
      REG_DEPTH:     prdata = {8'd0, cfg_q.bias_depth};
      default:       prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tds_ctrl.sv -----
`default_nettype none
module tds_ctrl
  import tds_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic bypass_i,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output tds_cmd_t  cmd_o
);

  tds_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = bypass_i ? ST_BYP : ST_MPRE;
      ST_BYP:   state_d = ST_DONE;
      ST_MPRE:  state_d = ST_WS;
      ST_WS:    state_d = ST_MENV;
      ST_MENV:  state_d = ST_WE;
      ST_WE:    state_d = ST_MBIAS;
      ST_MBIAS: state_d = ST_WU;
      ST_WU:    state_d = ST_SEG;
      ST_SEG:   state_d = ST_MT2;
      ST_MT2:   state_d = ST_WT2;
      ST_WT2:   state_d = ST_MT3;
      ST_MT3:   state_d = ST_WT3;
      ST_WT3:   state_d = ST_A0;
      ST_A0:    state_d = ST_A1;
      ST_A1:    state_d = ST_A2;
      ST_A2:    state_d = ST_A3;
      ST_A3:    state_d = ST_A4;
      ST_A4:    state_d = ST_DLD;
      ST_DLD:   state_d = ST_MQ;
      ST_MQ:    state_d = ST_WQ;
      ST_WQ:    state_d = ST_MQD;
      ST_MQD:   state_d = ST_WY;
      ST_WY:    state_d = ST_MHP;
      ST_MHP:   state_d = ST_WLP;
      ST_WLP:   state_d = ST_MPOST;
      ST_MPOST: state_d = ST_WR;
      ST_WR:    state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load_in  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.load_out = 1'b0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.op       = OP_NONE;
    out_valid_d    = out_valid_q && out_stall_i;
    case (state_q)
      ST_BYP:   cmd_o.op = OP_WB_BYP;
      ST_MPRE:  cmd_o.mul_sel = MUL_X_PRE;
      ST_WS:    cmd_o.op = OP_WB_S;
      ST_MENV:  cmd_o.mul_sel = MUL_C_DIFF;
      ST_WE:    cmd_o.op = OP_WB_ENV;
      ST_MBIAS: cmd_o.mul_sel = MUL_BIAS_E;
      ST_WU:    cmd_o.op = OP_WB_U;
      ST_SEG:   cmd_o.op = OP_SEG;
      ST_MT2:   cmd_o.mul_sel = MUL_T_T;
      ST_WT2:   cmd_o.op = OP_WB_T2;
      ST_MT3:   cmd_o.mul_sel = MUL_T2_T;
      ST_WT3:   cmd_o.op = OP_WB_T3;
      ST_A0:    cmd_o.mul_sel = MUL_VAL0_H00;
      ST_A1: begin
        cmd_o.mul_sel = MUL_SLP0_H10;
        cmd_o.op      = OP_ACC_LD;
      end
      ST_A2: begin
        cmd_o.mul_sel = MUL_VAL1_H01;
        cmd_o.op      = OP_ACC_ADD;
      end
      ST_A3: begin
        cmd_o.mul_sel = MUL_SLP1_H11;
        cmd_o.op      = OP_ACC_ADD;
      end
      ST_A4:    cmd_o.op = OP_ACC_ADD;
      ST_DLD:   cmd_o.op = OP_DIV_LD;
      ST_MQ:    cmd_o.mul_sel = MUL_N_RECIP;
      ST_WQ:    cmd_o.op = OP_WB_Q;
      ST_MQD:   cmd_o.mul_sel = MUL_Q_UNIT;
      ST_WY:    cmd_o.op = OP_WB_Y;
      ST_MHP:   cmd_o.mul_sel = MUL_HP_DIFF;
      ST_WLP:   cmd_o.op = OP_WB_LP;
      ST_MPOST: cmd_o.mul_sel = MUL_POST_DIFF;
      ST_WR:    cmd_o.op = OP_WB_R;
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tds_dpath.sv -----
`default_nettype none
module tds_dpath
  import tds_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  tds_cfg_t                cfg_i,
  input  tds_cmd_t                cmd_i,
  input  wire logic signed [23:0] sample_in_i,
  output logic signed [27:0]      sample_out_o
);

  localparam logic [19:0] ONE = 20'(1) << FRAC_BITS;
  localparam logic signed [27:0] EDGE = 28'sd1 <<< (FRAC_BITS + 3);

  logic signed [23:0] x_q;
  logic signed [25:0] s_q;
  logic        [25:0] env_q;
  logic signed [27:0] u_q;
  logic        [5:0]  idx_q;
  logic        [19:0] t_q, t2_q, t3_q;
  logic signed [PW-1:0] p_q, acc_q;
  logic        [49:0] n_q;
  logic        [23:0] q_q;
  logic               neg_q;
  logic signed [23:0] y_q, dc_q;
  logic signed [27:0] res_q, out_q;

  // envelope and DC tracker are state
  logic        [25:0] mag;
  logic signed [26:0] env_diff;
  logic        [22:0] env_c;
  logic signed [24:0] y_dc;
  logic signed [23:0] h00, h10, h01, h11;
  logic        [6:0]  k0, k1;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic signed [PW-1:0] rnd24, rnd20;
  logic signed [27:0] e_new, e_err;
  logic signed [27:0] u_new;
  logic        [24:0] pos;
  logic        [49:0] dmag;
  logic        [28:0] rem_lo;
  logic        [23:0] q_fin;
  logic signed [24:0] lp_new, lp_err;
  logic signed [PW-1:0] r_wide;

  assign mag      = s_q[25] ? 26'(-s_q) : 26'(s_q);
  assign env_diff = $signed({1'b0, mag}) - $signed({1'b0, env_q});
  assign env_c    = (mag > env_q) ? cfg_i.attack_coeff : cfg_i.release_coeff;
  assign y_dc     = 25'(y_q) - 25'(dc_q);
  assign k0       = {1'b0, idx_q};
  assign k1       = {1'b0, idx_q} + 7'd1;

  // hermite basis weights
  always_comb begin
    logic signed [23:0] t, t2, t3;
    t   = $signed({4'd0, t_q});
    t2  = $signed({4'd0, t2_q});
    t3  = $signed({4'd0, t3_q});
    h00 = 24'sd2 * t3 - 24'sd3 * t2 + $signed({4'd0, ONE});
    h10 = t3 - 24'sd2 * t2 + t;
    h01 = 24'sd3 * t2 - 24'sd2 * t3;
    h11 = t3 - t2;
  end

  always_comb begin
    op_a = 32'sd0;
    op_b = 32'sd0;
    case (cmd_i.mul_sel)
      MUL_X_PRE: begin
        op_a = 32'(x_q);
        op_b = $signed({7'd0, cfg_i.pre_gain});
      end
      MUL_C_DIFF: begin
        op_a = 32'(env_diff);
        op_b = $signed({9'd0, env_c});
      end
      MUL_BIAS_E: begin
        op_a = $signed({6'd0, env_q});
        op_b = $signed({8'd0, cfg_i.bias_depth});
      end
      MUL_T_T: begin
        op_a = $signed({12'd0, t_q});
        op_b = $signed({12'd0, t_q});
      end
      MUL_T2_T: begin
        op_a = $signed({12'd0, t2_q});
        op_b = $signed({12'd0, t_q});
      end
      MUL_VAL0_H00: begin
        op_a = 32'(KNOT_VAL[k0]);
        op_b = 32'(h00);
      end
      MUL_SLP0_H10: begin
        op_a = 32'(KNOT_SLOPE[k0]);
        op_b = 32'(h10);
      end
      MUL_VAL1_H01: begin
        op_a = 32'(KNOT_VAL[k1]);
        op_b = 32'(h01);
      end
      MUL_SLP1_H11: begin
        op_a = 32'(KNOT_SLOPE[k1]);
        op_b = 32'(h11);
      end
      MUL_HP_DIFF: begin
        op_a = 32'(y_dc);
        op_b = $signed({9'd0, cfg_i.highpass_coeff});
      end
      MUL_POST_DIFF: begin
        op_a = 32'(y_dc);
        op_b = $signed({8'd0, cfg_i.post_gain});
      end
      MUL_N_RECIP: begin
        op_a = $signed({8'd0, n_q[49:26]});
        op_b = $signed({1'b0, UNIT_RECIP});
      end
      MUL_Q_UNIT: begin
        op_a = $signed({8'd0, q_q});
        op_b = $signed({4'd0, TABLE_UNIT});
      end
      default: ;
    endcase
  end

  assign prod  = op_a * op_b;
  assign rnd24 = round_shift(p_q, COEF_SHIFT);
  assign rnd20 = round_shift(p_q, POST_SHIFT);

  assign e_new  = 28'($signed({1'b0, env_q})) + 28'(rnd24);
  assign e_err  = e_new - $signed({2'b0, mag});
  assign u_new  = 28'(s_q) - 28'(rnd24);
  assign pos    = {u_q[22:0], 2'b00} + (25'd1 << 24);
  assign dmag   = (acc_q[PW-1] ? 50'(-acc_q) : 50'(acc_q)) + HALF_UNIT;
  // reciprocal estimate is low by at most one, the remainder settles it
  assign rem_lo = n_q[28:0] - p_q[28:0];
  assign q_fin  = q_q + {23'd0, (rem_lo >= {1'b0, TABLE_UNIT})};
  assign lp_new = 25'(dc_q) + 25'(rnd24);
  assign lp_err = lp_new - 25'(y_q);
  assign r_wide = rnd20;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
      dc_q  <= '0;
    end else begin
      case (cmd_i.op)
        OP_WB_ENV: begin
          if (e_err >= -28'sd1 && e_err <= 28'sd1) env_q <= mag;
          else env_q <= e_new[25:0];
        end
        OP_WB_LP: begin
          if (lp_err >= -25'sd1 && lp_err <= 25'sd1) dc_q <= y_q;
          else dc_q <= lp_new[23:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) x_q <= sample_in_i;
    if (cmd_i.load_out) out_q <= res_q;
    if (cmd_i.mul_sel != MUL_NONE) p_q <= prod[PW-1:0];
    case (cmd_i.op)
      OP_WB_S: s_q <= rnd24[25:0];
      OP_WB_U: u_q <= u_new;
      OP_SEG: begin
        if (u_q <= -EDGE) begin
          idx_q <= 6'd0;
          t_q   <= 20'd0;
        end else if (u_q >= EDGE) begin
          // end of the last segment lands exactly on the last knot
          idx_q <= 6'(CURVE_KNOTS - 2);
          t_q   <= ONE;
        end else begin
          idx_q <= pos[24:FRAC_BITS];
          t_q   <= {1'b0, pos[FRAC_BITS-1:0]};
        end
      end
      OP_WB_T2:   t2_q  <= p_q[FRAC_BITS+19:FRAC_BITS];
      OP_WB_T3:   t3_q  <= p_q[FRAC_BITS+19:FRAC_BITS];
      OP_ACC_LD:  acc_q <= p_q;
      OP_ACC_ADD: acc_q <= acc_q + p_q;
      OP_DIV_LD: begin
        neg_q <= acc_q[PW-1];
        n_q   <= dmag;
      end
      OP_WB_Q: q_q <= p_q[RECIP_SHIFT+23:RECIP_SHIFT];
      OP_WB_Y: y_q <= neg_q ? -$signed({1'b0, q_fin[22:0]}) : $signed({1'b0, q_fin[22:0]});
      OP_WB_R: begin
        if (r_wide > PW'(OUT_MAX)) res_q <= OUT_MAX;
        else if (r_wide < PW'(OUT_MIN)) res_q <= OUT_MIN;
        else res_q <= r_wide[27:0];
      end
      OP_WB_BYP: res_q <= 28'(x_q);
      default: ;
    endcase
  end

  assign sample_out_o = out_q;

endmodule
`default_nettype wire

// ----- dv/triode_drive_stage_top_test.sv -----
`default_nettype none
module triode_drive_stage_top_test;
  import tds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 1 << 19;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [23:0] sample_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [27:0] sample_out_o;

  triode_drive_stage_top u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shaper's own copy of registers and state
  logic        cfg_bypass;
  logic [24:0] cfg_pre;
  logic [23:0] cfg_post;
  logic [22:0] cfg_att, cfg_rel, cfg_hp;
  logic [23:0] cfg_depth;
  longint      env_q, dc_q;

  logic signed [27:0] expected_samples[$];
  int errors = 0;
  int idle_cycles = 0;
  int sender_mode = 0;  // 0 bursty, 1 always valid
  int stall_mode = 0;   // 0 pattern, 1 never, 2 heavy

  function automatic longint rnd_shift(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint rnd_unit(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 64'sd50000000) / 64'sd100000000;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint labs(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint transfer_curve(longint u);
    longint p, t, t2, t3, acc;
    int i;
    if (u <= -8 * ONE) return rnd_unit(longint'(KNOT_VAL[0]) * ONE);
    if (u >= 8 * ONE) return rnd_unit(longint'(KNOT_VAL[CURVE_KNOTS-1]) * ONE);
    p = u * 4 + 32 * ONE;
    i = int'(p >>> 19);
    if (i > CURVE_KNOTS - 2) i = CURVE_KNOTS - 2;
    t = p & (ONE - 1);
    t2 = (t * t) >>> 19;
    t3 = (t2 * t) >>> 19;
    acc = longint'(KNOT_VAL[i]) * (2 * t3 - 3 * t2 + ONE)
        + longint'(KNOT_SLOPE[i]) * (t3 - 2 * t2 + t)
        + longint'(KNOT_VAL[i+1]) * (3 * t2 - 2 * t3)
        + longint'(KNOT_SLOPE[i+1]) * (t3 - t2);
    return rnd_unit(acc);
  endfunction

  function automatic logic signed [27:0] shape_sample(logic signed [23:0] xin);
    longint x, s, mag, e, u, y, lp, r, c;
    x = longint'(xin);
    if (cfg_bypass) return 28'(x);
    s = rnd_shift(x * longint'(cfg_pre), 24);
    mag = labs(s);
    c = (mag > env_q) ? longint'(cfg_att) : longint'(cfg_rel);
    e = env_q + rnd_shift(c * (mag - env_q), 24);
    if (labs(e - mag) <= 1) e = mag;
    env_q = longint'(e[31:0]);
    u = s - rnd_shift(longint'(cfg_depth) * e, 24);
    y = transfer_curve(u);
    lp = dc_q + rnd_shift(longint'(cfg_hp) * (y - dc_q), 24);
    if (labs(lp - y) <= 1) lp = y;
    dc_q = longint'(int'(lp[31:0]));
    r = rnd_shift((y - lp) * longint'(cfg_post), 20);
    if (r > 134217727) r = 134217727;
    if (r < -134217728) r = -134217728;
    return 28'(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BYPASS:    cfg_bypass = val[0];
      REG_PRE_GAIN:  cfg_pre = val[24:0];
      REG_POST_GAIN: cfg_post = val[23:0];
      REG_ATTACK:    cfg_att = val[22:0];
      REG_RELEASE:   cfg_rel = val[22:0];
      REG_HIGHPASS:  cfg_hp = val[22:0];
      REG_DEPTH:     cfg_depth = val[23:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [23:0] v);
    if (sender_mode == 0 && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_in_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    expected_samples.push_back(shape_sample(v));
  endtask

  task automatic stop_sender;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'sh7FFFFF;
      2: return -24'sh800000;
      3: return 24'($signed($urandom_range(0, 2 * ONE)) - ONE);
      default: return 24'($signed($urandom_range(0, 16 * ONE)) - 8 * ONE);
    endcase
  endfunction

  task automatic test_bypass;
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    send_sample(24'sh000000);
    send_sample(-24'sh000001);
    send_sample(24'($urandom));
    stop_sender();
    drain();
  endtask

  task automatic test_directed_extremes;
    write_reg(REG_BYPASS, 32'd0);
    write_reg(REG_PRE_GAIN, 32'd16777216);
    write_reg(REG_POST_GAIN, 32'd8388608);
    send_sample(24'sh7FFFFF);   // curve clamps high end
    send_sample(-24'sh800000);  // curve clamps low end
    send_sample(24'sh0);
    send_sample(24'sh1);
    send_sample(-24'sh1);
    send_sample(24'sh7FFFFF);
    stop_sender();
    drain();
    write_reg(REG_UNUSED, 32'hFFFFFFFF);  // ignored index
    send_sample(24'sh400000);
    send_sample(-24'sh400000);
    stop_sender();
    drain();
    write_reg(REG_PRE_GAIN, 32'd2097152);
    write_reg(REG_POST_GAIN, 32'd1048576);
    write_reg(REG_ATTACK, 32'd0);
    write_reg(REG_RELEASE, 32'd0);
    write_reg(REG_HIGHPASS, 32'd0);
    write_reg(REG_DEPTH, 32'd0);
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    send_sample(24'sh123456);
    stop_sender();
    drain();
    // full-scale values; the attack write is wider than its field and is masked to width
    write_reg(REG_ATTACK, 32'hFFFFFFFF);
    write_reg(REG_RELEASE, 32'h7FFFFF);
    write_reg(REG_HIGHPASS, 32'h7FFFFF);
    write_reg(REG_DEPTH, 32'hFFFFFF);
    write_reg(REG_PRE_GAIN, 32'h1FFFFFF);
    write_reg(REG_POST_GAIN, 32'hFFFFFF);
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    send_sample(24'sh0);
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh000001);
    stop_sender();
    drain();
  endtask

  task automatic test_random_settings;
    for (int phase = 0; phase < 12; phase++) begin
      write_reg(REG_BYPASS, (phase % 6 == 5) ? 32'd1 : 32'd0);
      write_reg(REG_PRE_GAIN, $urandom_range(2097152, 16777216));
      write_reg(REG_POST_GAIN, $urandom_range(1048576, 8388608));
      write_reg(REG_ATTACK, $urandom_range(0, 4194304));
      write_reg(REG_RELEASE, $urandom_range(0, 4194304));
      write_reg(REG_HIGHPASS, $urandom_range(0, 4194304));
      write_reg(REG_DEPTH, $urandom_range(0, 8388608));
      sender_mode = phase % 3 == 1;
      stall_mode = phase % 3;
      for (int n = 0; n < 94; n++) send_sample(rand_sample());
      stop_sender();
      drain();
    end
    stall_mode = 0;
    sender_mode = 0;
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    case (stall_mode)
      1: out_stall_i <= 1'b0;
      2: out_stall_i <= $urandom_range(0, 3) != 0;
      default: out_stall_i <= ($urandom_range(0, 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected beat", sample_out_o, 0);
        end else begin
          logic signed [27:0] want;
          want = expected_samples.pop_front();
          if (sample_out_o !== want) report_mismatch("sample_out", sample_out_o, want);
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  initial begin
    cfg_bypass = 1'b1; cfg_pre = 25'd2097152; cfg_post = 24'd8388608;
    cfg_att = 23'd69760; cfg_rel = 23'd6989; cfg_hp = 23'd21946; cfg_depth = 24'd620757;
    env_q = 0; dc_q = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_bypass();
    test_directed_extremes();
    test_random_settings();
    drain();
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
